// ===== sv/first_fit_capacity_queue_unit_defines.svh =====
// Assertion macros used by the checker file of the queue unit.
`ifndef FIRST_FIT_CAPACITY_QUEUE_UNIT_DEFINES_SVH
`define FIRST_FIT_CAPACITY_QUEUE_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FFCQ_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define FFCQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/ffcq_pkg.sv =====
`timescale 1ns / 1ps
package ffcq_pkg;

  localparam int DEPTH    = 16;
  localparam int TAG_BITS = 16;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);

  // Fixed field widths of the words on the channels.
  localparam int CMD_W  = 2;
  localparam int TAGF_W = 16;
  localparam int SIZE_W = 8;
  localparam int CAP_W  = 10;
  localparam int KIND_W = 3;
  localparam int OCC_W  = 5;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SERVE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DUMP   = 2'd2;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERTED   = 3'd0,
    KIND_FULL       = 3'd1,
    KIND_SERVED     = 3'd2,
    KIND_DONE       = 3'd3,
    KIND_EMPTY      = 3'd4,
    KIND_LISTED     = 3'd5,
    KIND_LIST_EMPTY = 3'd6
  } kind_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_INSERT,
    OP_FULL,
    OP_TAKE,
    OP_SKIP,
    OP_DONE,
    OP_EMPTY,
    OP_LIST,
    OP_LIST_EMPTY
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic full;
    logic walk_end;
    logic fits;
    logic list_last;
    logic can_emit;
  } dp_stat_t;

endpackage

// ===== sv/ffcq_if.sv =====
`timescale 1ns / 1ps
interface ffcq_in_if;
  logic                           valid;
  logic                           ready;
  logic [ffcq_pkg::CMD_W-1:0]     cmd;
  logic [ffcq_pkg::TAGF_W-1:0]    entry_tag;
  logic [ffcq_pkg::SIZE_W-1:0]    party_size;
  logic [ffcq_pkg::CAP_W-1:0]     seat_capacity;

  modport source (output valid, cmd, entry_tag, party_size, seat_capacity, input ready);
  modport sink   (input valid, cmd, entry_tag, party_size, seat_capacity, output ready);
endinterface

interface ffcq_out_if;
  logic                           valid;
  logic                           ready;
  logic [ffcq_pkg::KIND_W-1:0]    kind;
  logic [ffcq_pkg::TAGF_W-1:0]    out_tag;
  logic [ffcq_pkg::SIZE_W-1:0]    out_size;
  logic [ffcq_pkg::CAP_W-1:0]     remaining_capacity;
  logic [ffcq_pkg::OCC_W-1:0]     occupancy;
  logic                           last;

  modport source (output valid, kind, out_tag, out_size, remaining_capacity, occupancy, last,
                  input ready);
  modport sink   (input valid, kind, out_tag, out_size, remaining_capacity, occupancy, last,
                  output ready);
endinterface

// ===== sv/ffcq_ctrl.sv =====
`timescale 1ns / 1ps
module ffcq_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic [ffcq_pkg::CMD_W-1:0] in_cmd_i,
  output logic                       in_ready_o,
  input  ffcq_pkg::dp_stat_t         stat_i,
  output ffcq_pkg::dp_cmd_t          cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_INSERT  = 5'b00010,
    S_SERVE   = 5'b00100,
    S_NOSERVE = 5'b01000,
    S_DUMP    = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = ffcq_pkg::OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.op = ffcq_pkg::OP_LOAD;
          case (in_cmd_i)
            ffcq_pkg::CMD_INSERT: state_d = S_INSERT;
            ffcq_pkg::CMD_SERVE:  state_d = stat_i.count_zero ? S_NOSERVE : S_SERVE;
            ffcq_pkg::CMD_DUMP:   state_d = S_DUMP;
            default:              state_d = S_IDLE;
          endcase
        end
      end
      S_INSERT: begin
        if (stat_i.can_emit) begin
          cmd_o.op = stat_i.full ? ffcq_pkg::OP_FULL : ffcq_pkg::OP_INSERT;
          state_d  = S_IDLE;
        end
      end
      S_NOSERVE: begin
        if (stat_i.can_emit) begin
          cmd_o.op = ffcq_pkg::OP_EMPTY;
          state_d  = S_IDLE;
        end
      end
      S_SERVE: begin
        // A request that does not fit is passed over without producing a word.
        if (stat_i.walk_end) begin
          if (stat_i.can_emit) begin
            cmd_o.op = ffcq_pkg::OP_DONE;
            state_d  = S_IDLE;
          end
        end else if (!stat_i.fits) begin
          cmd_o.op = ffcq_pkg::OP_SKIP;
        end else if (stat_i.can_emit) begin
          cmd_o.op = ffcq_pkg::OP_TAKE;
        end
      end
      S_DUMP: begin
        if (stat_i.can_emit) begin
          if (stat_i.count_zero) begin
            cmd_o.op = ffcq_pkg::OP_LIST_EMPTY;
            state_d  = S_IDLE;
          end else begin
            cmd_o.op = ffcq_pkg::OP_LIST;
            if (stat_i.list_last) begin
              state_d = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/ffcq_dp.sv =====
`timescale 1ns / 1ps
module ffcq_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ffcq_pkg::dp_cmd_t           cmd_i,
  output ffcq_pkg::dp_stat_t          stat_o,
  input  logic [ffcq_pkg::TAGF_W-1:0] in_tag_i,
  input  logic [ffcq_pkg::SIZE_W-1:0] in_size_i,
  input  logic [ffcq_pkg::CAP_W-1:0]  in_cap_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [ffcq_pkg::KIND_W-1:0] out_kind_o,
  output logic [ffcq_pkg::TAGF_W-1:0] out_tag_o,
  output logic [ffcq_pkg::SIZE_W-1:0] out_size_o,
  output logic [ffcq_pkg::CAP_W-1:0]  out_cap_o,
  output logic [ffcq_pkg::OCC_W-1:0]  out_occ_o,
  output logic                        out_last_o
);

  localparam int DEPTH  = ffcq_pkg::DEPTH;
  localparam int TB     = ffcq_pkg::TAG_BITS;
  localparam int CNT_W  = ffcq_pkg::CNT_W;
  localparam int IDX_W  = ffcq_pkg::IDX_W;
  localparam int TAGF_W = ffcq_pkg::TAGF_W;
  localparam int SIZE_W = ffcq_pkg::SIZE_W;
  localparam int CAP_W  = ffcq_pkg::CAP_W;
  localparam int OCC_W  = ffcq_pkg::OCC_W;

  // Queue entries, head at slot zero.
  logic [TB-1:0]     tag_mem_q  [DEPTH];
  logic [SIZE_W-1:0] size_mem_q [DEPTH];

  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic              out_valid_q, out_valid_d;

  logic [TB-1:0]     new_tag_q;
  logic [SIZE_W-1:0] new_size_q;
  logic [CAP_W-1:0]  cap_q;

  logic [ffcq_pkg::KIND_W-1:0] kind_q;
  logic [TAGF_W-1:0]           otag_q;
  logic [SIZE_W-1:0]           osize_q;
  logic [CAP_W-1:0]            ocap_q;
  logic [OCC_W-1:0]            occ_q;
  logic                        last_q;

  logic [TB-1:0]       rd_tag;
  logic [SIZE_W-1:0]   rd_size;
  logic [CAP_W-1:0]    cap_left;
  logic [TB+TAGF_W-1:0]   in_tag_ext;
  logic [TAGF_W+TB-1:0]   rd_tag_ext;
  logic [TAGF_W+TB-1:0]   new_tag_ext;
  logic [OCC_W+CNT_W-1:0] occ_now_ext;
  logic [OCC_W+CNT_W-1:0] occ_inc_ext;
  logic [OCC_W+CNT_W-1:0] occ_dec_ext;
  logic                   emit;
  logic                   can_emit;

  assign rd_tag  = tag_mem_q[idx_q[IDX_W-1:0]];
  assign rd_size = size_mem_q[idx_q[IDX_W-1:0]];

  assign cap_left    = cap_q - {{(CAP_W-SIZE_W){1'b0}}, rd_size};
  assign in_tag_ext  = {{TB{1'b0}}, in_tag_i};
  assign rd_tag_ext  = {{TAGF_W{1'b0}}, rd_tag};
  assign new_tag_ext = {{TAGF_W{1'b0}}, new_tag_q};
  assign occ_now_ext = {{OCC_W{1'b0}}, count_q};
  assign occ_inc_ext = {{OCC_W{1'b0}}, count_q + CNT_W'(1)};
  assign occ_dec_ext = {{OCC_W{1'b0}}, count_q - CNT_W'(1)};

  assign can_emit = !out_valid_q || out_ready_i;

  assign stat_o.count_zero = (count_q == '0);
  assign stat_o.full       = (count_q >= CNT_W'(DEPTH));
  assign stat_o.walk_end   = (idx_q >= count_q) || (cap_q == '0);
  assign stat_o.fits       = ({{(CAP_W-SIZE_W){1'b0}}, rd_size} <= cap_q);
  assign stat_o.list_last  = ((idx_q + CNT_W'(1)) == count_q);
  assign stat_o.can_emit   = can_emit;

  always_comb begin
    emit = 1'b0;
    case (cmd_i.op)
      ffcq_pkg::OP_INSERT, ffcq_pkg::OP_FULL, ffcq_pkg::OP_TAKE, ffcq_pkg::OP_DONE,
      ffcq_pkg::OP_EMPTY, ffcq_pkg::OP_LIST, ffcq_pkg::OP_LIST_EMPTY: emit = 1'b1;
      default: emit = 1'b0;
    endcase
  end

  always_comb begin
    count_d     = count_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end
    case (cmd_i.op)
      ffcq_pkg::OP_LOAD:   idx_d   = '0;
      ffcq_pkg::OP_INSERT: count_d = count_q + CNT_W'(1);
      ffcq_pkg::OP_TAKE:   count_d = count_q - CNT_W'(1);
      ffcq_pkg::OP_SKIP:   idx_d   = idx_q + CNT_W'(1);
      ffcq_pkg::OP_LIST:   idx_d   = idx_q + CNT_W'(1);
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Entry storage: appends at the tail, and a removal pulls every later entry
  // up one slot in the same cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == ffcq_pkg::OP_INSERT) begin
      tag_mem_q[count_q[IDX_W-1:0]]  <= new_tag_q;
      size_mem_q[count_q[IDX_W-1:0]] <= new_size_q;
    end else if (cmd_i.op == ffcq_pkg::OP_TAKE) begin
      for (int j = 0; j < DEPTH - 1; j++) begin
        if (CNT_W'(j) >= idx_q) begin
          tag_mem_q[j]  <= tag_mem_q[j+1];
          size_mem_q[j] <= size_mem_q[j+1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == ffcq_pkg::OP_LOAD) begin
      new_tag_q  <= in_tag_ext[TB-1:0];
      new_size_q <= in_size_i;
      cap_q      <= in_cap_i;
    end else if (cmd_i.op == ffcq_pkg::OP_TAKE) begin
      cap_q <= cap_left;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      otag_q  <= '0;
      osize_q <= '0;
      ocap_q  <= '0;
      occ_q   <= occ_now_ext[OCC_W-1:0];
      last_q  <= 1'b1;
      case (cmd_i.op)
        ffcq_pkg::OP_INSERT: begin
          kind_q  <= ffcq_pkg::KIND_INSERTED;
          otag_q  <= new_tag_ext[TAGF_W-1:0];
          osize_q <= new_size_q;
          occ_q   <= occ_inc_ext[OCC_W-1:0];
        end
        ffcq_pkg::OP_FULL: begin
          kind_q <= ffcq_pkg::KIND_FULL;
        end
        ffcq_pkg::OP_TAKE: begin
          kind_q  <= ffcq_pkg::KIND_SERVED;
          otag_q  <= rd_tag_ext[TAGF_W-1:0];
          osize_q <= rd_size;
          ocap_q  <= cap_left;
          occ_q   <= occ_dec_ext[OCC_W-1:0];
          last_q  <= 1'b0;
        end
        ffcq_pkg::OP_DONE: begin
          kind_q <= ffcq_pkg::KIND_DONE;
          ocap_q <= cap_q;
        end
        ffcq_pkg::OP_LIST: begin
          kind_q  <= ffcq_pkg::KIND_LISTED;
          otag_q  <= rd_tag_ext[TAGF_W-1:0];
          osize_q <= rd_size;
          last_q  <= stat_o.list_last;
        end
        ffcq_pkg::OP_LIST_EMPTY: begin
          kind_q <= ffcq_pkg::KIND_LIST_EMPTY;
          occ_q  <= '0;
        end
        default: begin
          kind_q <= ffcq_pkg::KIND_EMPTY;
          occ_q  <= '0;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = kind_q;
  assign out_tag_o   = otag_q;
  assign out_size_o  = osize_q;
  assign out_cap_o   = ocap_q;
  assign out_occ_o   = occ_q;
  assign out_last_o  = last_q;

endmodule

// ===== sv/first_fit_capacity_queue_unit.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Word
// in_i     sink       cmd, entry_tag, party_size, seat_capacity
// out_o    source     kind, out_tag, out_size, remaining_capacity, occupancy, last
//
// One command is worked at a time; in_i is ready only while no command is open.
// Insert and the empty cases load the command and then emit one word; a dump emits one
// word per entry. A serve walks the entry store and ends with a done word; the walk
// reads one slot per cycle while out_o is not stalled.
// Every result word waits in the output register while out_o is stalled.
// Reset (rst_ni, asynchronous) empties the queue; entry contents are not cleared.
module first_fit_capacity_queue_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  ffcq_in_if.sink     in_i,
  ffcq_out_if.source  out_o
);

  ffcq_pkg::dp_cmd_t  dp_cmd;
  ffcq_pkg::dp_stat_t dp_stat;
  logic               in_ready;

  ffcq_ctrl u_ffcq_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_cmd_i   (in_i.cmd),
    .in_ready_o (in_ready),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  ffcq_dp u_ffcq_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .stat_o      (dp_stat),
    .in_tag_i    (in_i.entry_tag),
    .in_size_i   (in_i.party_size),
    .in_cap_i    (in_i.seat_capacity),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_kind_o  (out_o.kind),
    .out_tag_o   (out_o.out_tag),
    .out_size_o  (out_o.out_size),
    .out_cap_o   (out_o.remaining_capacity),
    .out_occ_o   (out_o.occupancy),
    .out_last_o  (out_o.last)
  );

  assign in_i.ready = in_ready;

endmodule

// ===== sv/ffcq_checker.sv =====
`timescale 1ns / 1ps
`include "first_fit_capacity_queue_unit_defines.svh"
module ffcq_port_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [ffcq_pkg::KIND_W-1:0] kind_i,
  input logic [ffcq_pkg::TAGF_W-1:0] out_tag_i,
  input logic [ffcq_pkg::SIZE_W-1:0] out_size_i,
  input logic [ffcq_pkg::CAP_W-1:0]  cap_i,
  input logic [ffcq_pkg::OCC_W-1:0]  occ_i,
  input logic                        last_i
);

  localparam int WORD_W = ffcq_pkg::KIND_W + ffcq_pkg::TAGF_W + ffcq_pkg::SIZE_W
                        + ffcq_pkg::CAP_W + ffcq_pkg::OCC_W + 1;
  localparam int unsigned FULL_OCC_I = ffcq_pkg::DEPTH;
  localparam logic [ffcq_pkg::OCC_W-1:0] FULL_OCC = FULL_OCC_I[ffcq_pkg::OCC_W-1:0];

  logic              stalled;
  logic [WORD_W-1:0] out_word;
  logic              full_word;
  logic              mid_word;
  logic              mid_kind;
  logic              empty_word;
  logic              empty_clean;

  assign stalled     = out_valid_i && !out_ready_i;
  assign out_word    = {kind_i, out_tag_i, out_size_i, cap_i, occ_i, last_i};
  assign full_word   = out_valid_i && (kind_i == ffcq_pkg::KIND_FULL);
  assign mid_word    = out_valid_i && !last_i;
  assign mid_kind    = (kind_i == ffcq_pkg::KIND_SERVED) || (kind_i == ffcq_pkg::KIND_LISTED);
  assign empty_word  = out_valid_i && ((kind_i == ffcq_pkg::KIND_EMPTY) ||
                                       (kind_i == ffcq_pkg::KIND_LIST_EMPTY));
  assign empty_clean = (occ_i == '0) && (out_tag_i == '0) && (out_size_i == '0) &&
                       (cap_i == '0) && last_i;

  `FFCQ_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, stalled, out_valid_i && $stable(out_word), "word changed")

  `FFCQ_ASSERT_NOW(a_full_occ, clk_i, rst_ni, full_word, occ_i == FULL_OCC, "full reject below depth")

  `FFCQ_ASSERT_NOW(a_not_last, clk_i, rst_ni, mid_word, mid_kind, "bad non-final word")

  `FFCQ_ASSERT_NOW(a_empty_word, clk_i, rst_ni, empty_word, empty_clean, "empty word not clean")

endmodule

bind first_fit_capacity_queue_unit ffcq_port_checker u_ffcq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .kind_i      (out_o.kind),
  .out_tag_i   (out_o.out_tag),
  .out_size_i  (out_o.out_size),
  .cap_i       (out_o.remaining_capacity),
  .occ_i       (out_o.occupancy),
  .last_i      (out_o.last)
);
